// ===== sv/kdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kdpc_pkg
// Types and constants shared by the key debounce and press classifier.
// ----------------------------------------------------------------------------
package kdpc_pkg;

	localparam int KIDX_W     = 3;
	localparam int SEQ_W      = 32;
	localparam int INTEG_W    = 8;
	localparam int HTICK_W    = 16;
	localparam int HPER_W     = 2;
	localparam int MASK_W     = 6;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [HPER_W-1:0] LONG_PERIODS = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 2'd2;

	localparam logic [INTEG_W-1:0] DEBOUNCE_RESET = 8'd4;
	localparam logic [HTICK_W-1:0] PRESS_RESET    = 16'd150;
	localparam logic [SEQ_W-1:0]   SEQ_RESET      = 32'd1;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_RELEASE = 3'd1,
		EV_SHORT   = 3'd2,
		EV_LONG    = 3'd3,
		EV_REPEAT  = 3'd4
	} ev_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_EMIT,
		ST_FLUSH
	} st_t;

	// per-key entry of the state memory
	typedef struct packed {
		logic               stable;
		logic [INTEG_W-1:0] integ;
		logic [HTICK_W-1:0] htick;
		logic [HPER_W-1:0]  hper;
		logic [SEQ_W-1:0]   kseq;
	} key_state_t;

	// key index in the lowest bits, as on the output bus
	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		ev_kind_t          kind;
		logic [KIDX_W-1:0] key;
	} ev_t;

	typedef struct packed {
		logic [1:0] ev_cnt;
		ev_kind_t   kind0;
		ev_kind_t   kind1;
		logic       seq_inc;
	} upd_ev_t;

	typedef struct packed {
		logic valid;
		ev_t  ev;
	} ev_push_t;

	typedef struct packed {
		logic push_ok;
		logic flush_done;
	} eq_status_t;

endpackage

// ===== sv/key_debounce_press_classifier_top.sv =====
// Flow: each input beat is a tick; for every key in turn the sequencer reads
// the single state memory, writes back the update, emits that key's events
// and moves on, then flushes the last held event; result-side stalls hold it.
// A new tick is taken only once the previous one has been flushed.
// Reset: asynchronous; all keys released, sequence number back to one.
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_top
// Debounces up to six keys and classifies presses as short, long or
// repeat, visiting the per-key state memory one key after another.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier_top #(
	parameter int KEYS = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// s_tdata: key_levels [5:0], zero [7:6]
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [kdpc_pkg::IN_TDATA_W-1:0]       s_tdata,
	// m_tdata: key_index [2:0], event_kind [5:3], sequence_number [37:6], zero [39:38]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [kdpc_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [kdpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [kdpc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int AW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int KW = kdpc_pkg::KIDX_W;

	kdpc_pkg::st_t                 st_q, st_d;
	logic [AW-1:0]                 key_q;
	logic [KEYS-1:0]               levels_q;
	logic [kdpc_pkg::SEQ_W-1:0]    next_seq_q;
	logic [kdpc_pkg::INTEG_W-1:0]  debounce_q;
	logic [kdpc_pkg::HTICK_W-1:0]  press_q;
	logic [kdpc_pkg::MASK_W-1:0]   invert_q;
	kdpc_pkg::upd_ev_t             evs_q;
	logic [kdpc_pkg::SEQ_W-1:0]    ev_seq_q;
	logic [1:0]                    ev_idx_q;

	kdpc_pkg::key_state_t          rd_state;
	kdpc_pkg::key_state_t          upd_state;
	kdpc_pkg::upd_ev_t             upd_evs;
	kdpc_pkg::ev_push_t            push;
	kdpc_pkg::eq_status_t          eq_status;
	logic                          in_acc;
	logic                          rd_en;
	logic                          wr_en;
	logic                          flush;
	logic                          emit_done;
	logic                          last_key;
	logic                          lvl;

	assign in_acc    = s_tvalid && s_tready;
	assign last_key  = (key_q == AW'(KEYS - 1));
	assign emit_done = (ev_idx_q == evs_q.ev_cnt);
	assign lvl       = levels_q[key_q];
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			kdpc_pkg::ST_IDLE: begin
				if (in_acc) st_d = kdpc_pkg::ST_READ;
			end
			kdpc_pkg::ST_READ: st_d = kdpc_pkg::ST_CALC;
			kdpc_pkg::ST_CALC: st_d = kdpc_pkg::ST_EMIT;
			kdpc_pkg::ST_EMIT: begin
				if (emit_done) st_d = last_key ? kdpc_pkg::ST_FLUSH : kdpc_pkg::ST_READ;
			end
			kdpc_pkg::ST_FLUSH: begin
				if (eq_status.flush_done) st_d = kdpc_pkg::ST_IDLE;
			end
			default: st_d = kdpc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready   = (st_q == kdpc_pkg::ST_IDLE);
		rd_en      = (st_q == kdpc_pkg::ST_READ);
		wr_en      = (st_q == kdpc_pkg::ST_CALC);
		flush      = (st_q == kdpc_pkg::ST_FLUSH);
		push.valid = (st_q == kdpc_pkg::ST_EMIT) && !emit_done;
		push.ev.key  = KW'(key_q);
		push.ev.kind = ev_idx_q[0] ? evs_q.kind1 : evs_q.kind0;
		push.ev.seq  = ev_seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= kdpc_pkg::ST_IDLE;
			key_q      <= '0;
			next_seq_q <= kdpc_pkg::SEQ_RESET;
			debounce_q <= kdpc_pkg::DEBOUNCE_RESET;
			press_q    <= kdpc_pkg::PRESS_RESET;
			invert_q   <= '0;
			evs_q      <= '0;
			ev_idx_q   <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					kdpc_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data[kdpc_pkg::INTEG_W-1:0];
					kdpc_pkg::CFG_PRESS:    press_q    <= cfg_data;
					kdpc_pkg::CFG_INVERT:   invert_q   <= cfg_data[kdpc_pkg::MASK_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				key_q <= '0;
			end
			if (st_q == kdpc_pkg::ST_CALC) begin
				evs_q    <= upd_evs;
				ev_idx_q <= '0;
				if (upd_evs.seq_inc) next_seq_q <= next_seq_q + 32'd1;
			end
			if (push.valid && eq_status.push_ok) begin
				ev_idx_q <= ev_idx_q + 2'd1;
			end
			// advance to the next key once its events are out
			if (st_q == kdpc_pkg::ST_EMIT && emit_done && !last_key) begin
				key_q <= key_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			levels_q <= s_tdata[KEYS-1:0] ^ invert_q[KEYS-1:0];
		end
		if (st_q == kdpc_pkg::ST_CALC) begin
			ev_seq_q <= upd_state.kseq;
		end
	end

	kdpc_state_ram #(
		.KEYS (KEYS),
		.AW   (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (key_q),
		.rd_data (rd_state),
		.wr_en   (wr_en),
		.wr_addr (key_q),
		.wr_data (upd_state)
	);

	kdpc_key_update u_upd (
		.cur            (rd_state),
		.lvl            (lvl),
		.debounce_ticks (debounce_q),
		.press_ticks    (press_q),
		.next_seq       (next_seq_q),
		.nxt            (upd_state),
		.evs            (upd_evs)
	);

	kdpc_event_queue u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.flush    (flush),
		.status   (eq_status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== sv/kdpc_state_ram.sv =====
// ----------------------------------------------------------------------------
// kdpc_state_ram
// Per-key state memory, one write and one registered read port, with
// per-entry valid bits so that unwritten entries read as released.
// ----------------------------------------------------------------------------
module kdpc_state_ram #(
	parameter int KEYS = 6,
	parameter int AW   = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output kdpc_pkg::key_state_t  rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  kdpc_pkg::key_state_t  wr_data
);

	kdpc_pkg::key_state_t mem [KEYS];
	kdpc_pkg::key_state_t rd_data_q;
	logic [KEYS-1:0]      vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/kdpc_key_update.sv =====
// ----------------------------------------------------------------------------
// kdpc_key_update
// Next-state and event logic for one key on one tick: integrator step,
// debounced edge, hold timer and period classification.
// ----------------------------------------------------------------------------
module kdpc_key_update (
	input  kdpc_pkg::key_state_t                 cur,
	input  logic                                 lvl,
	input  logic [kdpc_pkg::INTEG_W-1:0]         debounce_ticks,
	input  logic [kdpc_pkg::HTICK_W-1:0]         press_ticks,
	input  logic [kdpc_pkg::SEQ_W-1:0]           next_seq,
	output kdpc_pkg::key_state_t                 nxt,
	output kdpc_pkg::upd_ev_t                    evs
);

	logic [kdpc_pkg::INTEG_W-1:0] integ1;
	logic                         at_end;
	logic                         change;
	logic [kdpc_pkg::HTICK_W-1:0] tick1;

	always_comb begin
		nxt   = cur;
		evs   = '{ev_cnt: 2'd0, kind0: kdpc_pkg::EV_PRESS, kind1: kdpc_pkg::EV_PRESS,
			seq_inc: 1'b0};
		tick1 = '0;

		if (lvl) begin
			integ1 = (cur.integ < debounce_ticks) ? cur.integ + 8'd1 : cur.integ;
		end else begin
			integ1 = (cur.integ != '0) ? cur.integ - 8'd1 : cur.integ;
		end
		nxt.integ = integ1;

		// at or above the top counts as the upper end
		at_end = (integ1 == '0) || (integ1 >= debounce_ticks);
		change = at_end && (cur.stable != lvl);

		if (change && lvl) begin
			nxt.stable  = 1'b1;
			nxt.kseq    = next_seq;
			nxt.htick   = '0;
			nxt.hper    = '0;
			evs.seq_inc = 1'b1;
			evs.ev_cnt  = 2'd1;
			evs.kind0   = kdpc_pkg::EV_PRESS;
		end else if (change) begin
			nxt.stable = 1'b0;
			nxt.htick  = '0;
			nxt.hper   = '0;
			if (cur.hper < kdpc_pkg::LONG_PERIODS) begin
				evs.ev_cnt = 2'd2;
				evs.kind0  = kdpc_pkg::EV_SHORT;
				evs.kind1  = kdpc_pkg::EV_RELEASE;
			end else begin
				evs.ev_cnt = 2'd1;
				evs.kind0  = kdpc_pkg::EV_RELEASE;
			end
		end else if (cur.stable) begin
			// held through this tick: advance the timer
			tick1     = cur.htick + 16'd1;
			nxt.htick = tick1;
			if (tick1 >= press_ticks) begin
				nxt.htick = '0;
				if (cur.hper < kdpc_pkg::LONG_PERIODS) begin
					nxt.hper = cur.hper + 2'd1;
					if (cur.hper + 2'd1 == kdpc_pkg::LONG_PERIODS) begin
						evs.ev_cnt = 2'd1;
						evs.kind0  = kdpc_pkg::EV_LONG;
					end
				end else begin
					evs.ev_cnt = 2'd1;
					evs.kind0  = kdpc_pkg::EV_REPEAT;
				end
			end
		end
	end

endmodule

// ===== sv/kdpc_event_queue.sv =====
// ----------------------------------------------------------------------------
// kdpc_event_queue
// Holds back the newest event until the next one arrives or the tick ends,
// so that the final event of a tick can be marked, and drives the output
// register of the result stream.
// ----------------------------------------------------------------------------
module kdpc_event_queue (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  kdpc_pkg::ev_push_t                    push,
	input  logic                                  flush,
	output kdpc_pkg::eq_status_t                  status,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [kdpc_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                  m_tlast
);

	logic          pend_v_q;
	kdpc_pkg::ev_t pend_q;
	logic          out_v_q;
	kdpc_pkg::ev_t out_q;
	logic          out_last_q;
	logic          out_free;
	logic          push_ok;
	logic          move;
	logic          take_push;

	assign out_free  = !out_v_q || m_tready;
	assign push_ok   = !pend_v_q || out_free;
	assign take_push = push.valid && push_ok;
	assign move      = out_free && pend_v_q && (push.valid || flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (take_push) begin
				pend_v_q <= 1'b1;
			end else if (move) begin
				pend_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q      <= pend_q;
			out_last_q <= flush;
		end
		if (take_push) begin
			pend_q <= push.ev;
		end
	end

	assign status.push_ok    = push_ok;
	assign status.flush_done = !pend_v_q || out_free;

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== sv/kdpc_checker.sv =====
// ----------------------------------------------------------------------------
// kdpc_checker
// Port-level checks of the key debounce and press classifier.
// ----------------------------------------------------------------------------
module kdpc_checker #(
	parameter int KEYS = 6
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [kdpc_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input logic                                  m_tlast
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// one tick at a time: no input beat straight after another
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a tick is in work");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[5:3] <= kdpc_pkg::EV_REPEAT)
		else $error("unknown event kind");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] < KEYS)
		else $error("key index out of range");

	// short is always followed by its release in the same tick
	a_short_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5:3] == kdpc_pkg::EV_SHORT |-> !m_tlast)
		else $error("short event marked last of tick");

endmodule

bind key_debounce_press_classifier_top kdpc_checker #(
	.KEYS (KEYS)
) u_kdpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/sv/key_debounce_press_classifier_top_test.sv =====
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_top_test
// Drives key level ticks into the debounce and press classifier, keeps a
// model of every key's integrator, hold timer and sequence number, and checks
// each event beat against it. A directed table of ticks and register writes
// comes first, then random press and hold sequences with bounce noise under
// several register settings, random gaps on both sides and one long stall.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS         = 6;
	localparam int QUIET_CYCLES = 40;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 7;

	localparam logic [kdpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef logic [kdpc_pkg::CFG_DATA_W-1:0] cfg_word_t;
	typedef logic [kdpc_pkg::MASK_W-1:0]     mask_t;

	typedef enum logic {ROW_TICK, ROW_REG} row_op_t;

	typedef struct {
		row_op_t                         op;
		logic [kdpc_pkg::MASK_W-1:0]     raw;
		logic [kdpc_pkg::CFG_IDX_W-1:0]  idx;
		logic [kdpc_pkg::CFG_DATA_W-1:0] data;
		bit                              typed;
		int                              n_ev;
		kdpc_pkg::ev_kind_t              first;
	} row_t;

	typedef struct {
		logic [kdpc_pkg::MASK_W-1:0] raw;
		bit                          typed;
		int                          n_ev;
		kdpc_pkg::ev_kind_t          first;
	} tick_t;

	typedef struct {
		logic [kdpc_pkg::CFG_IDX_W-1:0]  idx;
		logic [kdpc_pkg::CFG_DATA_W-1:0] data;
	} reg_write_t;

	typedef struct packed {
		logic [kdpc_pkg::KIDX_W-1:0] key;
		kdpc_pkg::ev_kind_t          kind;
		logic [kdpc_pkg::SEQ_W-1:0]  seq;
		logic                        last;
	} key_event_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [kdpc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [kdpc_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             m_tlast;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [kdpc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [kdpc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	key_debounce_press_classifier_top #(
		.KEYS(KEYS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// model state and register copies
	logic                          key_stable [KEYS] = '{default: 1'b0};
	logic [kdpc_pkg::INTEG_W-1:0]  key_integ  [KEYS] = '{default: '0};
	logic [kdpc_pkg::HTICK_W-1:0]  key_htick  [KEYS] = '{default: '0};
	logic [kdpc_pkg::HPER_W-1:0]   key_hper   [KEYS] = '{default: '0};
	logic [kdpc_pkg::SEQ_W-1:0]    key_seq    [KEYS] = '{default: '0};
	logic [kdpc_pkg::SEQ_W-1:0]    seq_next     = kdpc_pkg::SEQ_RESET;
	logic [kdpc_pkg::INTEG_W-1:0]  debounce_top = kdpc_pkg::DEBOUNCE_RESET;
	logic [kdpc_pkg::HTICK_W-1:0]  hold_len     = kdpc_pkg::PRESS_RESET;
	logic [kdpc_pkg::MASK_W-1:0]   invert_bits  = '0;

	key_event_t  pending_events [$];
	tick_t       tick_q [$];
	reg_write_t  reg_q [$];

	int          errors = 0;
	int          ticks_pushed = 0;
	int          ticks_taken = 0;
	int          events_seen = 0;
	int          regs_written = 0;
	int          kind_seen [5] = '{default: 0};
	int unsigned send_gap_max = 4;
	int unsigned recv_gap_max = 4;
	bit          long_hold_req = 1'b0;
	int          cycle_count = 0;

	// debounce at reset values first, then long, repeat and the odd cases
	row_t plan [34] = '{
		'{ROW_TICK, 6'h3F, CFG_UNUSED, 16'h0000, 1'b1, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h3F, CFG_UNUSED, 16'h0000, 1'b1, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h3F, CFG_UNUSED, 16'h0000, 1'b1, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h3F, CFG_UNUSED, 16'h0000, 1'b1, 6,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b1, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b1, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b1, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b1, 12, kdpc_pkg::EV_SHORT},
		// upper data bits dropped, unused index ignored
		'{ROW_REG,  6'h00, kdpc_pkg::CFG_DEBOUNCE, 16'hAB02, 1'b0, 0, kdpc_pkg::EV_PRESS},
		'{ROW_REG,  6'h00, kdpc_pkg::CFG_PRESS,    16'h0002, 1'b0, 0, kdpc_pkg::EV_PRESS},
		'{ROW_REG,  6'h00, CFG_UNUSED,             16'hFFFF, 1'b0, 0, kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h01, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h01, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h01, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h01, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h01, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h01, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h01, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h01, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		// active-low keys 1, 3 and 5, slowest hold period
		'{ROW_REG,  6'h00, kdpc_pkg::CFG_INVERT,   16'hFFEA, 1'b0, 0, kdpc_pkg::EV_PRESS},
		'{ROW_REG,  6'h00, kdpc_pkg::CFG_DEBOUNCE, 16'h0005, 1'b0, 0, kdpc_pkg::EV_PRESS},
		'{ROW_REG,  6'h00, kdpc_pkg::CFG_PRESS,    16'hFFFF, 1'b0, 0, kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h00, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		// lower the top under a full integrator and the period under a running timer
		'{ROW_REG,  6'h00, kdpc_pkg::CFG_DEBOUNCE, 16'h0002, 1'b0, 0, kdpc_pkg::EV_PRESS},
		'{ROW_REG,  6'h00, kdpc_pkg::CFG_PRESS,    16'h0001, 1'b0, 0, kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h28, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS},
		'{ROW_TICK, 6'h28, CFG_UNUSED, 16'h0000, 1'b0, 0,  kdpc_pkg::EV_PRESS}
	};

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run timed out after %0d cycles", $time, cycle_count);
		$display("Mismatches found");
		$finish;
	end

	function automatic key_event_t key_event(int k, kdpc_pkg::ev_kind_t kind);
		key_event_t ev;
		ev.key  = k[kdpc_pkg::KIDX_W-1:0];
		ev.kind = kind;
		ev.seq  = key_seq[k];
		ev.last = 1'b0;
		return ev;
	endfunction

	// advance every key by one tick and queue the events it gives
	task automatic classify_tick(input logic [kdpc_pkg::MASK_W-1:0] raw, output int n_ev,
			output kdpc_pkg::ev_kind_t first);
		logic [kdpc_pkg::MASK_W-1:0] lv;
		key_event_t                  evs [$];
		bit                          pressed_now;
		lv = raw ^ invert_bits;
		for (int k = 0; k < KEYS; k++) begin
			pressed_now = 1'b0;
			if (lv[k]) begin
				if (key_integ[k] < debounce_top)
					key_integ[k]++;
			end else if (key_integ[k] != 0) begin
				key_integ[k]--;
			end
			if (!(key_integ[k] != 0 && key_integ[k] < debounce_top) &&
					key_stable[k] != lv[k]) begin
				key_stable[k] = lv[k];
				if (lv[k]) begin
					key_seq[k]   = seq_next;
					seq_next     = seq_next + 1;
					key_htick[k] = '0;
					key_hper[k]  = '0;
					pressed_now  = 1'b1;
					evs.push_back(key_event(k, kdpc_pkg::EV_PRESS));
				end else begin
					if (key_hper[k] < kdpc_pkg::LONG_PERIODS)
						evs.push_back(key_event(k, kdpc_pkg::EV_SHORT));
					key_hper[k]  = '0;
					key_htick[k] = '0;
					evs.push_back(key_event(k, kdpc_pkg::EV_RELEASE));
				end
			end
			if (key_stable[k] && !pressed_now) begin
				key_htick[k]++;
				if (key_htick[k] >= hold_len) begin
					key_htick[k] = '0;
					if (key_hper[k] < kdpc_pkg::LONG_PERIODS) begin
						key_hper[k]++;
						if (key_hper[k] == kdpc_pkg::LONG_PERIODS)
							evs.push_back(key_event(k, kdpc_pkg::EV_LONG));
					end else begin
						evs.push_back(key_event(k, kdpc_pkg::EV_REPEAT));
					end
				end
			end
		end
		n_ev  = evs.size();
		first = kdpc_pkg::EV_PRESS;
		if (n_ev != 0) begin
			evs[n_ev-1].last = 1'b1;
			first = evs[0].kind;
		end
		foreach (evs[i])
			pending_events.push_back(evs[i]);
	endtask

	task automatic queue_tick(input logic [kdpc_pkg::MASK_W-1:0] raw, input bit typed,
			input int n_ev, input kdpc_pkg::ev_kind_t first);
		tick_t t;
		t.raw   = raw;
		t.typed = typed;
		t.n_ev  = n_ev;
		t.first = first;
		tick_q.push_back(t);
		ticks_pushed++;
	endtask

	// wait for every tick and event, then let a tick with no events finish
	task automatic settle();
		while (ticks_taken != ticks_pushed || pending_events.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs();
		reg_write_t w;
		while (reg_q.size() != 0) begin
			w = reg_q.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data  <= w.data;
			do @(posedge clk); while (!cfg_ready);
			regs_written++;
			case (w.idx)
				kdpc_pkg::CFG_DEBOUNCE: debounce_top = w.data[kdpc_pkg::INTEG_W-1:0];
				kdpc_pkg::CFG_PRESS:    hold_len     = w.data[kdpc_pkg::HTICK_W-1:0];
				kdpc_pkg::CFG_INVERT:   invert_bits  = w.data[kdpc_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : tick_sender
		tick_t              t_cur;
		int                 n_ev;
		kdpc_pkg::ev_kind_t k0;
		int unsigned        gap;
		gap = 0;
		forever begin
			@(posedge clk);
			if (s_tvalid && s_tready) begin
				classify_tick(t_cur.raw, n_ev, k0);
				if (t_cur.typed &&
						(n_ev != t_cur.n_ev || (n_ev != 0 && k0 != t_cur.first))) begin
					$display("%0t: tick %0d expected %0d events first kind %0d,",
						$time, ticks_taken, t_cur.n_ev, t_cur.first,
						" got %0d first kind %0d", n_ev, k0);
					errors++;
				end
				ticks_taken++;
				gap = $urandom_range(0, send_gap_max);
			end
			if (!s_tvalid || s_tready) begin
				if (gap != 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					t_cur = tick_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(kdpc_pkg::IN_TDATA_W-kdpc_pkg::MASK_W){1'b0}}, t_cur.raw};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	initial begin : event_sink
		key_event_t  got;
		key_event_t  want;
		int unsigned pause;
		int unsigned hold_left;
		pause = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.key  = m_tdata[2:0];
				got.kind = kdpc_pkg::ev_kind_t'(m_tdata[5:3]);
				got.seq  = m_tdata[37:6];
				got.last = m_tlast;
				events_seen++;
				if (pending_events.size() == 0) begin
					$display("%0t: expected no event, got key %0d kind %0d seq %0d last %0b",
						$time, got.key, got.kind, got.seq, got.last);
					errors++;
				end else begin
					want = pending_events.pop_front();
					if (got !== want) begin
						$display("%0t: expected key %0d kind %0d seq %0d last %0b,",
							$time, want.key, want.kind, want.seq, want.last,
							" got key %0d kind %0d seq %0d last %0b",
							got.key, got.kind, got.seq, got.last);
						errors++;
					end else begin
						kind_seen[want.kind]++;
					end
				end
				pause = $urandom_range(0, recv_gap_max);
			end else if (pause != 0) begin
				pause--;
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end else if (hold_left != 0) begin
				hold_left--;
			end
			m_tready <= (pause == 0) && (hold_left == 0);
		end
	end

	initial begin : stimulus
		int                              deb;
		int                              plen;
		int                              lo;
		int                              hi;
		int                              n_ticks;
		logic [kdpc_pkg::MASK_W-1:0]     inv;
		logic [kdpc_pkg::MASK_W-1:0]     lv;
		logic [kdpc_pkg::CFG_DATA_W-1:0] wd;
		bit                              held [KEYS];
		int                              run_left [KEYS];
		foreach (held[k]) begin
			held[k] = 1'b0;
			run_left[k] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].op == ROW_REG) begin
				reg_q.push_back('{plan[r].idx, plan[r].data});
			end else begin
				if (reg_q.size() != 0) begin
					settle();
					program_regs();
				end
				queue_tick(plan[r].raw, plan[r].typed, plan[r].n_ev, plan[r].first);
			end
		end

		// random holds and releases with the odd bounce
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					deb = 2;
					plen = 1;
					inv = '0;
				end
				3: begin
					deb = 255;
					plen = 65535;
					inv = '1;
				end
				default: begin
					deb = $urandom_range(2, 4);
					plen = $urandom_range(1, 6);
					inv = mask_t'($urandom_range(0, 63));
				end
			endcase
			wd = cfg_word_t'($urandom);
			wd[kdpc_pkg::INTEG_W-1:0] = deb[kdpc_pkg::INTEG_W-1:0];
			reg_q.push_back('{kdpc_pkg::CFG_DEBOUNCE, wd});
			reg_q.push_back('{kdpc_pkg::CFG_PRESS, plen[kdpc_pkg::CFG_DATA_W-1:0]});
			wd = cfg_word_t'($urandom);
			wd[kdpc_pkg::MASK_W-1:0] = inv;
			reg_q.push_back('{kdpc_pkg::CFG_INVERT, wd});
			settle();
			program_regs();

			send_gap_max = (p % 2 == 0) ? 4 : 0;
			recv_gap_max = (p % 3 == 1) ? 0 : 4;
			if (p == 2)
				long_hold_req = 1'b1;

			lo = (deb < 40) ? deb : 40;
			hi = deb + 4 * plen + 2;
			if (hi > 40)
				hi = 40;
			n_ticks = (p == 3) ? 30 : 65;
			repeat (n_ticks) begin
				for (int k = 0; k < KEYS; k++) begin
					if (run_left[k] == 0) begin
						held[k] = ~held[k];
						if ($urandom_range(0, 3) == 0)
							run_left[k] = $urandom_range(1, 3);
						else
							run_left[k] = $urandom_range(lo, hi);
					end
					run_left[k]--;
					lv[k] = held[k] ^ ($urandom_range(0, 15) == 0);
				end
				queue_tick(lv ^ inv, 1'b0, 0, kdpc_pkg::EV_PRESS);
			end
		end

		while (ticks_taken != ticks_pushed || pending_events.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);

		$display("Ran %0d ticks under %0d register writes, %0d event beats checked",
			ticks_taken, regs_written, events_seen);
		$display("Events: %0d press, %0d release, %0d short, %0d long, %0d repeat",
			kind_seen[kdpc_pkg::EV_PRESS], kind_seen[kdpc_pkg::EV_RELEASE],
			kind_seen[kdpc_pkg::EV_SHORT], kind_seen[kdpc_pkg::EV_LONG],
			kind_seen[kdpc_pkg::EV_REPEAT]);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
